### rtl/core/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg: shared types and constants for the motor command serial block
// Result word layout, status codes, protocol characters and byte helpers.
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int MAX_RES   = 5;
    localparam int CNT_W     = 3;

    // Scaling: q = floor((mag * 127 + 500) / 1000) via reciprocal multiply.
    // Ties to even only occur at mag = 500, where round-half-up agrees.
    localparam logic [16:0] ROUND_BIAS  = 17'd500;
    localparam logic [9:0]  SPEED_MAX   = 10'd1000;
    localparam logic [17:0] RECIP       = 18'd134218;   // ceil(2^27 / 1000)
    localparam int          RECIP_SHIFT = 27;

    // Protocol characters, 7-bit ASCII
    localparam logic [6:0] CH_BANG = 7'h21;
    localparam logic [6:0] CH_CR   = 7'h0D;
    localparam logic [6:0] CH_PLUS = 7'h2B;
    localparam logic [6:0] CH_A_UP = 7'h41;
    localparam logic [6:0] CH_B_UP = 7'h42;
    localparam logic [6:0] CH_A_LO = 7'h61;
    localparam logic [6:0] CH_B_LO = 7'h62;
    localparam logic [6:0] CH_ZERO = 7'h30;

    localparam logic [15:0] SEARCH_LIMIT_RST = 16'd4096;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_PARITY = 3'd1,
        ST_ECHO   = 3'd2,
        ST_LIMIT  = 3'd3,
        ST_NACK   = 3'd4
    } t_status;

    typedef enum logic {
        FN_CMD = 1'b0,
        FN_RX  = 1'b1
    } t_func;

    typedef enum logic {
        KIND_TX     = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    // One accepted input word
    typedef struct packed {
        logic               func;
        logic               motor_select;
        logic signed [10:0] speed;
        logic [7:0]         rx_byte;
    } t_item;

    // One result word
    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [2:0] status;
    } t_res;

    // Result words produced by one item, slot 0 goes out first
    typedef struct packed {
        logic [CNT_W-1:0]      cnt;
        t_res [MAX_RES-1:0]    words;
    } t_load;

    function automatic logic [6:0] hex_digit(input logic [3:0] v);
        logic [6:0] d;
        if (v < 4'd10) begin
            d = CH_ZERO + 7'(v);
        end else begin
            d = CH_A_UP + 7'(v - 4'd10);
        end
        return d;
    endfunction

    // Transmit word with even parity in bit 7
    function automatic t_res mk_tx(input logic [6:0] ch, input logic last);
        t_res w;
        w.kind    = KIND_TX;
        w.tx_byte = {^ch, ch};
        w.tx_last = last;
        w.status  = ST_OK;
        return w;
    endfunction

    function automatic t_res mk_status(input t_status s);
        t_res w;
        w.kind    = KIND_STATUS;
        w.tx_byte = 8'd0;
        w.tx_last = 1'b0;
        w.status  = s;
        return w;
    endfunction

endpackage

### rtl/core/mcs_cmd_enc.sv
// ----------------------------------------------------------------------------
// mcs_cmd_enc: speed-to-command character encoder
// Clamps the signed speed, scales it to 0..127 and forms the letter and
// the two hex digits of the command.
// ----------------------------------------------------------------------------
module mcs_cmd_enc (
    input  logic               i_motor_select,
    input  logic signed [10:0] i_speed,
    output logic [6:0]         o_letter,
    output logic [6:0]         o_hex_hi,
    output logic [6:0]         o_hex_lo
);
    import mcs_pkg::*;

    logic               neg;
    logic signed [11:0] sp12;
    logic [11:0]        mag_full;
    logic [9:0]         mag;
    logic [16:0]        prod;
    logic [34:0]        full;
    logic [6:0]         q;

    // Magnitude and clamp
    assign neg      = i_speed[10];
    assign sp12     = 12'(i_speed);
    assign mag_full = neg ? 12'(-sp12) : 12'(sp12);
    assign mag      = (mag_full > 12'(SPEED_MAX)) ? SPEED_MAX : mag_full[9:0];

    // mag * 127 + 500, then divide by 1000 through the reciprocal
    assign prod = (17'(mag) << 7) - 17'(mag) + ROUND_BIAS;
    assign full = 35'(prod) * 35'(RECIP);
    assign q    = full[RECIP_SHIFT +: 7];

    // Letter: upper case forward, lower case reverse (also for a zero result)
    always_comb begin
        if (neg) begin
            o_letter = i_motor_select ? CH_B_LO : CH_A_LO;
        end else begin
            o_letter = i_motor_select ? CH_B_UP : CH_A_UP;
        end
    end

    assign o_hex_hi = hex_digit({1'b0, q[6:4]});
    assign o_hex_lo = hex_digit(q[3:0]);

endmodule

### rtl/core/mcs_txn_fsm.sv
// ----------------------------------------------------------------------------
// mcs_txn_fsm: transaction state machine
// Builds the command words, stores the echo characters and follows the
// reply byte by byte: search for '!', match the echo, then expect '+'.
// ----------------------------------------------------------------------------
module mcs_txn_fsm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  mcs_pkg::t_item  i_item,
    input  logic [15:0]     i_search_limit,
    output mcs_pkg::t_load  o_load
);
    import mcs_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEARCH,
        PH_MATCH,
        PH_ACK
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_idx,    n_idx;
    logic [15:0] r_skip,   n_skip;
    logic [6:0]  r_echo_letter, r_echo_hi, r_echo_lo;

    logic [6:0]  enc_letter, enc_hi, enc_lo;
    logic [6:0]  c;
    logic        perr;
    logic [15:0] skip_inc;
    logic [6:0]  expected;
    logic        is_cmd;

    mcs_cmd_enc u_enc (
        .i_motor_select (i_item.motor_select),
        .i_speed        (i_item.speed),
        .o_letter       (enc_letter),
        .o_hex_hi       (enc_hi),
        .o_hex_lo       (enc_lo)
    );

    assign is_cmd   = (i_item.func == FN_CMD);
    assign c        = i_item.rx_byte[6:0];
    assign perr     = ^i_item.rx_byte;
    assign skip_inc = r_skip + 16'd1;

    // Expected echo character at the current match position
    always_comb begin
        case (r_idx)
            3'd2:    expected = r_echo_hi;
            3'd3:    expected = r_echo_lo;
            3'd4:    expected = CH_CR;
            default: expected = r_echo_letter;
        endcase
    end

    // Next state and result words
    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_skip      = r_skip;
        o_load.cnt  = '0;
        o_load.words = '0;

        if (i_adv) begin
            if (is_cmd) begin
                o_load.words[0] = mk_tx(CH_BANG,    1'b0);
                o_load.words[1] = mk_tx(enc_letter, 1'b0);
                o_load.words[2] = mk_tx(enc_hi,     1'b0);
                o_load.words[3] = mk_tx(enc_lo,     1'b0);
                o_load.words[4] = mk_tx(CH_CR,      1'b1);
                o_load.cnt      = CNT_W'(MAX_RES);
                n_phase         = PH_SEARCH;
                n_idx           = '0;
                n_skip          = '0;
            end else if (r_phase != PH_IDLE) begin
                // Any transaction-ending byte yields one status word
                o_load.cnt = CNT_W'(1);
                n_phase    = PH_IDLE;
                n_idx      = '0;
                n_skip     = '0;
                if (perr) begin
                    o_load.words[0] = mk_status(ST_PARITY);
                end else begin
                    case (r_phase)
                        PH_SEARCH: begin
                            if (c == CH_BANG) begin
                                o_load.cnt = '0;
                                n_phase    = PH_MATCH;
                                n_idx      = 3'd1;
                            end else if (skip_inc >= i_search_limit) begin
                                o_load.words[0] = mk_status(ST_LIMIT);
                            end else begin
                                o_load.cnt = '0;
                                n_phase    = PH_SEARCH;
                                n_skip     = skip_inc;
                            end
                        end
                        PH_MATCH: begin
                            if (c != expected) begin
                                o_load.words[0] = mk_status(ST_ECHO);
                            end else if (r_idx == 3'd4) begin
                                o_load.cnt = '0;
                                n_phase    = PH_ACK;
                            end else begin
                                o_load.cnt = '0;
                                n_phase    = PH_MATCH;
                                n_idx      = (r_idx == 3'd0) ? 3'd2 : r_idx + 3'd1;
                            end
                        end
                        PH_ACK: begin
                            o_load.words[0] = mk_status((c == CH_PLUS) ? ST_OK : ST_NACK);
                        end
                        default: begin
                            o_load.cnt = '0;
                        end
                    endcase
                end
            end
        end
    end

    // State registers; echo characters carry no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_skip  <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_skip  <= n_skip;
        end
        if (i_adv && is_cmd) begin
            r_echo_letter <= enc_letter;
            r_echo_hi     <= enc_hi;
            r_echo_lo     <= enc_lo;
        end
    end

endmodule

### rtl/core/mcs_res_queue.sv
// ----------------------------------------------------------------------------
// mcs_res_queue: result word serializer
// Holds up to five result words and presents them one per handshake.
// ----------------------------------------------------------------------------
module mcs_res_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  mcs_pkg::t_load  i_data,
    output logic            o_can_load,
    output logic            o_valid,
    input  logic            i_ready,
    output mcs_pkg::t_res   o_word
);
    import mcs_pkg::*;

    logic [CNT_W-1:0]   r_cnt;
    t_res [MAX_RES-1:0] r_words;
    logic               fire;

    assign o_valid    = (r_cnt != '0);
    assign fire       = o_valid && i_ready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_ready);
    assign o_word     = r_words[0];

    // Count of pending words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_data.cnt;
        end else if (fire) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Word storage: load a full set or shift toward slot 0
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_words <= i_data.words;
        end else if (fire) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_words[i] <= r_words[i+1];
            end
        end
    end

endmodule

### rtl/core/motor_command_serial_transaction.sv
// ----------------------------------------------------------------------------
// motor_command_serial_transaction: motor command and reply tracker
// Input channel (i_valid/o_ready) takes either a motor command or one
// received serial byte. Output channel (o_valid/i_ready) gives transmit
// bytes and the transaction status. Config channel (i_cfg_valid/o_cfg_ready)
// writes the search limit; it is always ready and should be written idle.
// A command produces five transmit words ('!', letter, two hex digits, CR),
// given out one per handshake; a received byte produces no word or one
// status word. An accepted input word is held in the input register and
// is then loaded into the result serializer, which presents its first word.
// Received bytes sustain one word per cycle while the receiver is ready;
// the input stalls while earlier results are pending.
// A receiver stall holds the current output word and, once the input
// register is full, backs up the input channel.
// Synchronous reset: phase idle, no pending results, search limit 4096.
// ----------------------------------------------------------------------------
module motor_command_serial_transaction (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic               i_motor_select,
    input  logic signed [10:0] i_speed,
    input  logic [7:0]         i_rx_byte,
    // output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic [7:0]         o_tx_byte,
    output logic               o_tx_last,
    output logic [2:0]         o_status
);
    import mcs_pkg::*;

    logic [15:0] r_search_limit;
    logic        r_in_vld;
    t_item       r_in;
    logic        adv;
    logic        can_load;
    t_load       load;
    t_res        word;

    // Search limit register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_limit <= SEARCH_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_search_limit <= i_cfg_data;
        end
    end

    // Input register
    assign adv     = r_in_vld && can_load;
    assign o_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in.func         <= i_func;
            r_in.motor_select <= i_motor_select;
            r_in.speed        <= i_speed;
            r_in.rx_byte      <= i_rx_byte;
        end
    end

    mcs_txn_fsm u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_item         (r_in),
        .i_search_limit (r_search_limit),
        .o_load         (load)
    );

    mcs_res_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv),
        .i_data     (load),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_word     (word)
    );

    assign o_kind    = word.kind;
    assign o_tx_byte = word.tx_byte;
    assign o_tx_last = word.tx_last;
    assign o_status  = word.status;

endmodule

### rtl/core/mcs_checker.sv
// ----------------------------------------------------------------------------
// mcs_checker: port-level checks for the motor command block
// Watches the output channel; bound to the top level below.
// ----------------------------------------------------------------------------
module mcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_kind,
    input logic [7:0] o_tx_byte,
    input logic       o_tx_last,
    input logic [2:0] o_status
);
    import mcs_pkg::*;

    // A stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_tx_byte)
            && $stable(o_tx_last) && $stable(o_status))
        else $error("output word changed under stall");

    // Every transmit word carries even parity and an ok status
    a_tx_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_TX) |-> (^o_tx_byte == 1'b0) && (o_status == ST_OK))
        else $error("transmit word with bad parity or status");

    // Status words carry no byte and a known code
    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_STATUS) |-> (o_tx_byte == 8'd0) && !o_tx_last
            && (o_status <= ST_NACK))
        else $error("malformed status word");

    // Nothing is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind motor_command_serial_transaction mcs_checker u_mcs_checker (.*);
